>>> hdl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants of the calorimeter layer trigger
// Register indexes, reset values, field widths and the tower lane structs.
// ----------------------------------------------------------------------------
package clt_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned EnergyW = 24;
  localparam int unsigned PlateW  = 4;
  localparam int unsigned TowerW  = 1;
  localparam int unsigned LimitW  = 5;
  localparam int unsigned NeedW   = 2;
  localparam int unsigned CountW  = 6;
  localparam int unsigned AddrW   = 3;

  // Configuration register indexes
  typedef enum logic [AddrW-1:0] {
    RegShowerThr  = 3'd0,
    RegHighEmThr  = 3'd1,
    RegHighEmPl   = 3'd2,
    RegPi0Limit   = 3'd3,
    RegHitsNeeded = 3'd4,
    RegPi0Towers  = 3'd5
  } reg_idx_e;

  // Register reset values
  localparam logic [EnergyW-1:0] ShowerThrRst  = 24'd45000;
  localparam logic [EnergyW-1:0] HighEmThrRst  = 24'd500000;
  localparam logic [PlateW-1:0]  HighEmPlRst   = 4'd4;
  localparam logic [LimitW-1:0]  Pi0LimitRst   = 5'd7;
  localparam logic [LimitW-1:0]  HitsNeededRst = 5'd3;
  localparam logic [NeedW-1:0]   Pi0TowersRst  = 2'd2;

  // Saturation bounds of the up/down count
  localparam logic signed [CountW-1:0] CountMax = 6'sd31;
  localparam logic signed [CountW-1:0] CountMin = -6'sd32;

  // Lane configuration
  typedef struct packed {
    logic [LimitW-1:0] hits_needed;
    logic [LimitW-1:0] pi0_plate_limit;
  } lane_cfg_t;

  // Per-sample control broadcast to every lane
  typedef struct packed {
    logic              clear;   // last word of the event processed
    logic [PlateW-1:0] plate;
    logic              hit;     // energy above the shower threshold
  } lane_ctl_t;

  // Lane status back to the event logic
  typedef struct packed {
    logic reached;  // count reached hits_needed on this word
    logic fired;    // tower fired early, including this word
  } lane_sts_t;

endpackage

>>> hdl/clt_tower_lane.sv
// ----------------------------------------------------------------------------
// clt_tower_lane: per-tower up/down hit count
// Saturating signed count, restarted at plate 0, and the early-fire flag.
// ----------------------------------------------------------------------------
module clt_tower_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               upd_i,
  input  clt_pkg::lane_ctl_t ctl_i,
  input  clt_pkg::lane_cfg_t cfg_i,
  output clt_pkg::lane_sts_t sts_o
);

  logic signed [clt_pkg::CountW-1:0] count_q, count_d, base;
  logic                              fired_q, fired_d;
  logic                              reach;

  always_comb begin
    base = (ctl_i.plate == '0) ? '0 : count_q;
    if (ctl_i.hit) begin
      count_d = (base != clt_pkg::CountMax) ? base + 6'sd1 : base;
    end else begin
      count_d = (base != clt_pkg::CountMin) ? base - 6'sd1 : base;
    end
    reach = upd_i &&
            (count_d >= $signed({1'b0, cfg_i.hits_needed}));
    fired_d = fired_q ||
              (reach && ({1'b0, ctl_i.plate} < cfg_i.pi0_plate_limit));
  end

  assign sts_o.reached = reach;
  assign sts_o.fired   = fired_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fired_q <= 1'b0;
    end else if (ctl_i.clear) begin
      count_q <= '0;
      fired_q <= 1'b0;
    end else if (upd_i) begin
      count_q <= count_d;
      fired_q <= fired_d;
    end
  end

endmodule

>>> hdl/calorimeter_layer_trigger_core.sv
// ----------------------------------------------------------------------------
// calorimeter_layer_trigger_core: shower, pi0 and high-EM event trigger
// Path: the accepted last word passes the input register, then the result register.
// Throughput: one word per cycle while the result register is free for a last word;
//   the count update is combinational from the input register to the per-tower count registers.
// Reset: asynchronous active low; clears event state, valid flags and loads
//   the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
module calorimeter_layer_trigger_core #(
  parameter int unsigned TOWERS = 2,
  parameter int unsigned PLATES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port
  input  logic                        cfg_we_i,
  input  logic [clt_pkg::AddrW-1:0]   cfg_addr_i,
  input  logic [clt_pkg::EnergyW-1:0] cfg_wdata_i,
  // Sample stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // tower, plate[3:0], energy_kev[23:0]
  input  logic                        s_axis_tlast,
  // Trigger result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata   // shower, pi0, high_em, accepted, pad
);

  localparam int unsigned CntW = $clog2(TOWERS + 1);
  localparam int unsigned CmpW = (CntW > clt_pkg::NeedW) ? CntW : clt_pkg::NeedW;

  // Configuration registers
  logic [clt_pkg::EnergyW-1:0] shower_thr_q, high_em_thr_q;
  logic [clt_pkg::PlateW-1:0]  high_em_plate_q;
  logic [clt_pkg::LimitW-1:0]  pi0_limit_q, hits_needed_q;
  logic [clt_pkg::NeedW-1:0]   pi0_towers_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shower_thr_q    <= clt_pkg::ShowerThrRst;
      high_em_thr_q   <= clt_pkg::HighEmThrRst;
      high_em_plate_q <= clt_pkg::HighEmPlRst;
      pi0_limit_q     <= clt_pkg::Pi0LimitRst;
      hits_needed_q   <= clt_pkg::HitsNeededRst;
      pi0_towers_q    <= clt_pkg::Pi0TowersRst;
    end else if (cfg_we_i) begin
      unique case (clt_pkg::reg_idx_e'(cfg_addr_i))
        clt_pkg::RegShowerThr:  shower_thr_q    <= cfg_wdata_i;
        clt_pkg::RegHighEmThr:  high_em_thr_q   <= cfg_wdata_i;
        clt_pkg::RegHighEmPl:   high_em_plate_q <= cfg_wdata_i[clt_pkg::PlateW-1:0];
        clt_pkg::RegPi0Limit:   pi0_limit_q     <= cfg_wdata_i[clt_pkg::LimitW-1:0];
        clt_pkg::RegHitsNeeded: hits_needed_q   <= cfg_wdata_i[clt_pkg::LimitW-1:0];
        clt_pkg::RegPi0Towers:  pi0_towers_q    <= cfg_wdata_i[clt_pkg::NeedW-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Input register: hold one word between the stream and the count update
  logic                        in_vld_q;
  logic [clt_pkg::TowerW-1:0]  tower_q;
  logic [clt_pkg::PlateW-1:0]  plate_q;
  logic [clt_pkg::EnergyW-1:0] energy_q;
  logic                        last_q;

  logic out_free, go;

  // A last word needs a free result register; others always advance
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign go            = in_vld_q && (!last_q || out_free);
  assign s_axis_tready = !in_vld_q || go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tower_q  <= s_axis_tdata[0];
      plate_q  <= s_axis_tdata[4:1];
      energy_q <= s_axis_tdata[28:5];
      last_q   <= s_axis_tlast;
    end
  end

  // Sample checks; out-of-range tower or plate is not counted, may still end the event
  logic in_range, sample_ok;
  assign in_range  = (32'(tower_q) < TOWERS) && (32'(plate_q) < PLATES);
  assign sample_ok = go && in_range;

  clt_pkg::lane_ctl_t lane_ctl;
  clt_pkg::lane_cfg_t lane_cfg;
  clt_pkg::lane_sts_t lane_sts [TOWERS];

  assign lane_ctl.clear = go && last_q;
  assign lane_ctl.plate = plate_q;
  assign lane_ctl.hit   = energy_q > shower_thr_q;
  assign lane_cfg.hits_needed     = hits_needed_q;
  assign lane_cfg.pi0_plate_limit = pi0_limit_q;

  for (genvar t = 0; t < TOWERS; t++) begin : g_lane
    logic upd;
    assign upd = sample_ok && (32'(tower_q) == t);
    clt_tower_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .upd_i  (upd),
      .ctl_i  (lane_ctl),
      .cfg_i  (lane_cfg),
      .sts_o  (lane_sts[t])
    );
  end

  // Event flags, including the contribution of the current word
  logic            shower_seen_q, high_em_seen_q;
  logic            shower_now, high_em_now, pi0_now;
  logic [CntW-1:0] fired_cnt;

  always_comb begin
    shower_now = shower_seen_q;
    fired_cnt  = '0;
    for (int t = 0; t < TOWERS; t++) begin
      shower_now = shower_now || lane_sts[t].reached;
      fired_cnt  = fired_cnt + CntW'(lane_sts[t].fired);
    end
    high_em_now = high_em_seen_q ||
                  (sample_ok && (plate_q == high_em_plate_q) &&
                   (energy_q > high_em_thr_q));
    pi0_now = (CmpW'(fired_cnt) == CmpW'(pi0_towers_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shower_seen_q  <= 1'b0;
      high_em_seen_q <= 1'b0;
    end else if (lane_ctl.clear) begin
      shower_seen_q  <= 1'b0;
      high_em_seen_q <= 1'b0;
    end else if (go) begin
      shower_seen_q  <= shower_now;
      high_em_seen_q <= high_em_now;
    end
  end

  // Result register: load on the last word, hold until taken
  logic       out_vld_q;
  logic [3:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= lane_ctl.clear;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lane_ctl.clear) begin
      res_q <= {shower_now || pi0_now || high_em_now, high_em_now, pi0_now, shower_now};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, res_q};

endmodule

>>> bench/calorimeter_layer_trigger_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calorimeter_layer_trigger_core_tb: self-checking bench for the layer trigger
// Streams plate samples into the core under several register settings and checks
// every trigger word against a fixed word (typed directed rows) or an in-bench model
// of the up/down layer count, the pi0 tower count and the high-EM plate check.
// ----------------------------------------------------------------------------
module calorimeter_layer_trigger_core_tb;

  // One plate sample as it travels on the input stream
  typedef struct packed {
    logic                        last;
    logic [clt_pkg::EnergyW-1:0] energy;
    logic [clt_pkg::PlateW-1:0]  plate;
    logic                        tower;
  } sample_t;

  // Trigger word, laid out as in m_axis_tdata[3:0]
  typedef struct packed {
    logic accepted;
    logic high_em;
    logic pi0;
    logic shower;
  } flags_t;

  // Register set, at the widths of the configuration fields
  typedef struct {
    logic [clt_pkg::EnergyW-1:0] shower_thr;
    logic [clt_pkg::EnergyW-1:0] hem_thr;
    logic [clt_pkg::PlateW-1:0]  hem_plate;
    logic [clt_pkg::LimitW-1:0]  pi0_limit;
    logic [clt_pkg::LimitW-1:0]  hits;
    logic [clt_pkg::NeedW-1:0]   towers;
  } trig_cfg_t;

  // Directed stimulus row: a fixed trigger word is used where typed is set
  typedef struct {
    sample_t s;
    bit      typed;
    flags_t  want;
  } row_t;

  localparam logic [clt_pkg::EnergyW-1:0] EnergyTop = '1;
  localparam int unsigned                 PhaseWords = 140;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [clt_pkg::AddrW-1:0]   cfg_addr_i = '0;
  logic [clt_pkg::EnergyW-1:0] cfg_wdata_i = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [31:0]                 s_axis_tdata = '0;  // tower, plate[3:0], energy_kev[23:0], pad
  logic                        s_axis_tlast = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [7:0]                  m_axis_tdata;       // shower, pi0, high_em, accepted, pad

  // Model copy of the registers, loaded with the reset values
  trig_cfg_t cfg_now = '{clt_pkg::ShowerThrRst, clt_pkg::HighEmThrRst,
                         clt_pkg::HighEmPlRst, clt_pkg::Pi0LimitRst,
                         clt_pkg::HitsNeededRst, clt_pkg::Pi0TowersRst};

  // Model copy of the event state
  logic signed [clt_pkg::CountW-1:0] run_count[2] = '{default: '0};
  bit                                early_fire[2] = '{default: 1'b0};
  bit                                shower_flag = 1'b0;
  bit                                high_em_flag = 1'b0;

  flags_t trigger_q[$];     // trigger words still owed by the core
  int     mismatches = 0;
  int     sent_words = 0;
  int     burst_left = 0;

  // Receiver stall pattern: stall while ph_cnt is below stall_len in each period
  int     seg_left = 0;
  int     period = 1;
  int     stall_len = 0;
  int     ph_cnt = 0;

  calorimeter_layer_trigger_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Advance the event state by one sample; on the last sample hand back the
  // trigger word and clear the event. Tower and plate fields are too narrow
  // to leave the TOWERS x PLATES range, so no sample is dropped here.
  task automatic predict_trigger(input sample_t s, output bit emits, output flags_t f);
    int          cnt;
    int unsigned fired;
    // Plate 0 restarts the count; any other plate carries on from the stored value
    cnt = (s.plate == '0) ? 0 : int'(run_count[s.tower]);
    if (s.energy > cfg_now.shower_thr) begin
      cnt = (cnt < int'(clt_pkg::CountMax)) ? cnt + 1 : int'(clt_pkg::CountMax);
    end else begin
      cnt = (cnt > int'(clt_pkg::CountMin)) ? cnt - 1 : int'(clt_pkg::CountMin);
    end
    run_count[s.tower] = clt_pkg::CountW'(cnt);
    if (cnt >= int'(cfg_now.hits)) begin
      shower_flag = 1'b1;
      if (s.plate < cfg_now.pi0_limit) early_fire[s.tower] = 1'b1;
    end
    if (s.plate == cfg_now.hem_plate && s.energy > cfg_now.hem_thr) high_em_flag = 1'b1;
    emits = s.last;
    f = '0;
    if (s.last) begin
      fired = 0;
      for (int t = 0; t < 2; t++) if (early_fire[t]) fired++;
      f.shower   = shower_flag;
      f.pi0      = (fired == cfg_now.towers);
      f.high_em  = high_em_flag;
      f.accepted = f.shower | f.pi0 | f.high_em;
      run_count   = '{default: '0};
      early_fire  = '{default: 1'b0};
      shower_flag = 1'b0;
      high_em_flag = 1'b0;
    end
  endtask

  // Present one word and hold it until the core takes it. Entered and left in
  // the time step of a rising edge. Bursts of words are separated by random gaps.
  task automatic send_word(input sample_t s, input bit typed, input flags_t want);
    int     gap;
    bit     rdy;
    bit     emits;
    flags_t f;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, s.energy, s.plate, s.tower};
    s_axis_tlast  <= s.last;
    // Sample ready on the falling edge before the edge that would take the word
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    burst_left--;
    sent_words++;
    predict_trigger(s, emits, f);
    if (emits) trigger_q.push_back(typed ? want : f);
  endtask

  // Drop valid, let every owed word arrive, then cover the core's latency
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    while (trigger_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all six registers on consecutive edges, then update the model copy
  task automatic apply_config(input trig_cfg_t c);
    clt_pkg::reg_idx_e regs[6] = '{clt_pkg::RegShowerThr, clt_pkg::RegHighEmThr,
                                   clt_pkg::RegHighEmPl, clt_pkg::RegPi0Limit,
                                   clt_pkg::RegHitsNeeded, clt_pkg::RegPi0Towers};
    for (int i = 0; i < 6; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= regs[i];
      case (regs[i])
        clt_pkg::RegShowerThr:  cfg_wdata_i <= c.shower_thr;
        clt_pkg::RegHighEmThr:  cfg_wdata_i <= c.hem_thr;
        clt_pkg::RegHighEmPl:   cfg_wdata_i <= clt_pkg::EnergyW'(c.hem_plate);
        clt_pkg::RegPi0Limit:   cfg_wdata_i <= clt_pkg::EnergyW'(c.pi0_limit);
        clt_pkg::RegHitsNeeded: cfg_wdata_i <= clt_pkg::EnergyW'(c.hits);
        default:                cfg_wdata_i <= clt_pkg::EnergyW'(c.towers);
      endcase
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_now = c;
  endtask

  function automatic trig_cfg_t mk_cfg(input logic [clt_pkg::EnergyW-1:0] st, ht,
                                       input logic [clt_pkg::PlateW-1:0] hp,
                                       input logic [clt_pkg::LimitW-1:0] lim, hits,
                                       input logic [clt_pkg::NeedW-1:0] tw);
    trig_cfg_t c;
    c.shower_thr = st;
    c.hem_thr    = ht;
    c.hem_plate  = hp;
    c.pi0_limit  = lim;
    c.hits       = hits;
    c.towers     = tw;
    return c;
  endfunction

  function automatic row_t mk_row(input logic tower,
                                  input logic [clt_pkg::PlateW-1:0] plate,
                                  input logic [clt_pkg::EnergyW-1:0] energy,
                                  input logic last,
                                  input bit typed, input flags_t want);
    row_t r;
    r.s     = {last, energy, plate, tower};
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // Plate energy: mostly above or below the shower threshold as asked, with
  // threshold corners and high-EM candidates mixed in
  function automatic logic [clt_pkg::EnergyW-1:0] pick_energy(
      input logic [clt_pkg::PlateW-1:0] plate, input bit want_hit);
    logic [clt_pkg::EnergyW-1:0] thr_up;
    logic [clt_pkg::EnergyW-1:0] hem_up;
    int unsigned                 roll;
    thr_up = (cfg_now.shower_thr == EnergyTop) ? EnergyTop : cfg_now.shower_thr + 1'b1;
    hem_up = (cfg_now.hem_thr == EnergyTop) ? EnergyTop : cfg_now.hem_thr + 1'b1;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      case ($urandom_range(0, 5))
        0:       return '0;
        1:       return EnergyTop;
        2:       return cfg_now.shower_thr;
        3:       return thr_up;
        4:       return cfg_now.hem_thr;
        default: return hem_up;
      endcase
    end
    if (plate == cfg_now.hem_plate && roll < 30) begin
      return clt_pkg::EnergyW'($urandom_range(EnergyTop, hem_up));
    end
    if (want_hit && cfg_now.shower_thr != EnergyTop) begin
      return clt_pkg::EnergyW'($urandom_range(EnergyTop, thr_up));
    end
    return clt_pkg::EnergyW'($urandom_range(cfg_now.shower_thr, 0));
  endfunction

  // One event: mostly complete towers in plate order, some short broken
  // events, and some long runs that never restart so the count saturates
  task automatic send_shower_event();
    int      kind;
    int      hit_pct;
    int      len;
    int      first;
    int      ntow;
    bit      hit;
    sample_t s;
    kind    = $urandom_range(0, 99);
    hit_pct = $urandom_range(0, 100);
    if (kind < 70) begin
      first = $urandom_range(0, 1);
      ntow  = ($urandom_range(0, 9) == 0) ? 1 : 2;
      for (int k = 0; k < ntow; k++) begin
        for (int p = 0; p < 16; p++) begin
          s.tower  = first[0] ^ k[0];
          s.plate  = clt_pkg::PlateW'(p);
          s.energy = pick_energy(s.plate, $urandom_range(0, 99) < hit_pct);
          s.last   = (k == ntow - 1) && (p == 15);
          send_word(s, 1'b0, '0);
        end
      end
    end else if (kind < 88) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        s.tower  = 1'($urandom_range(0, 1));
        s.plate  = clt_pkg::PlateW'($urandom_range(0, 15));
        s.energy = pick_energy(s.plate, $urandom_range(0, 99) < hit_pct);
        s.last   = (i == len - 1);
        send_word(s, 1'b0, '0);
      end
    end else begin
      len     = $urandom_range(34, 72);
      s.tower = 1'($urandom_range(0, 1));
      hit     = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++) begin
        // Hold hits or misses in long blocks so the count hits both rails
        if ($urandom_range(0, 11) == 0) hit = ~hit;
        s.plate  = (i == 0 && $urandom_range(0, 1)) ? '0
                                                    : clt_pkg::PlateW'($urandom_range(1, 15));
        s.energy = pick_energy(s.plate, hit);
        s.last   = (i == len - 1);
        send_word(s, 1'b0, '0);
      end
    end
  endtask

  // Receiver: stall on a periodic pattern that changes whenever seg_left runs
  // out, with some stretches of no stall at all
  always @(posedge clk_i) begin
    if (seg_left == 0) begin
      seg_left  = $urandom_range(16, 200);
      period    = $urandom_range(1, 9);
      stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, period - 1);
      ph_cnt    = $urandom_range(0, period - 1);
    end
    seg_left--;
    ph_cnt = (ph_cnt + 1) % period;
    m_axis_tready <= (ph_cnt >= stall_len);
  end

  task automatic cmp_field(input string name, input bit want, input bit got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Check each trigger word on the falling edge before the edge that takes it
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (trigger_q.size() == 0) begin
        $error("trigger word 0x%02h with nothing pending", m_axis_tdata);
        mismatches++;
      end else begin
        cmp_field("shower_trigger", trigger_q[0].shower, m_axis_tdata[0]);
        cmp_field("pi0_trigger", trigger_q[0].pi0, m_axis_tdata[1]);
        cmp_field("high_em_trigger", trigger_q[0].high_em, m_axis_tdata[2]);
        cmp_field("accepted", trigger_q[0].accepted, m_axis_tdata[3]);
        void'(trigger_q.pop_front());
      end
    end
  end

  initial begin
    int        phase_start;
    trig_cfg_t plan[$];
    trig_cfg_t c;
    row_t      rows[$];

    // Register settings, one per phase; phase 0 runs on the reset values
    plan.push_back(cfg_now);
    plan.push_back(mk_cfg('0, '0, 4'd0, 5'd0, 5'd0, 2'd0));
    plan.push_back(mk_cfg(EnergyTop, EnergyTop, 4'd15, 5'd31, 5'd31, 2'd3));
    plan.push_back(mk_cfg(24'd45000, 24'd1000, 4'd15, 5'd16, 5'd16, 2'd1));
    plan.push_back(mk_cfg(24'd100000, 24'd500000, 4'd0, 5'd1, 5'd1, 2'd2));
    for (int i = 0; i < 4; i++) begin
      c.shower_thr = clt_pkg::EnergyW'($urandom_range(0, 1) ? $urandom_range(1000, 200000)
                                                            : $urandom);
      c.hem_thr    = clt_pkg::EnergyW'($urandom_range(0, 1) ? $urandom_range(100000, 900000)
                                                            : $urandom);
      c.hem_plate  = clt_pkg::PlateW'($urandom_range(0, 15));
      c.pi0_limit  = clt_pkg::LimitW'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 16)
                                                                  : $urandom_range(0, 31));
      c.hits       = clt_pkg::LimitW'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 8)
                                                                  : $urandom_range(0, 31));
      c.towers     = clt_pkg::NeedW'($urandom_range(0, 3));
      plan.push_back(c);
    end
    plan.push_back(mk_cfg(clt_pkg::ShowerThrRst, clt_pkg::HighEmThrRst,
                          clt_pkg::HighEmPlRst, clt_pkg::Pi0LimitRst,
                          clt_pkg::HitsNeededRst, clt_pkg::Pi0TowersRst));

    // Directed rows under the reset values; flags are {accepted, high_em, pi0, shower}
    // Lone empty sample: nothing fires, two towers are needed for pi0
    rows.push_back(mk_row(1'b0, 4'd0, 24'd0, 1'b1, 1'b1, flags_t'(4'b0000)));
    // Three full plates in both towers: shower and pi0
    rows.push_back(mk_row(1'b0, 4'd0, EnergyTop, 1'b0, 1'b0, '0));
    rows.push_back(mk_row(1'b0, 4'd1, EnergyTop, 1'b0, 1'b0, '0));
    rows.push_back(mk_row(1'b0, 4'd2, EnergyTop, 1'b0, 1'b0, '0));
    rows.push_back(mk_row(1'b1, 4'd0, EnergyTop, 1'b0, 1'b0, '0));
    rows.push_back(mk_row(1'b1, 4'd1, EnergyTop, 1'b0, 1'b0, '0));
    rows.push_back(mk_row(1'b1, 4'd2, EnergyTop, 1'b1, 1'b1, flags_t'(4'b1011)));
    // High-EM plate just above and exactly at its threshold
    rows.push_back(mk_row(1'b0, 4'd4, 24'd500001, 1'b1, 1'b1, flags_t'(4'b1100)));
    rows.push_back(mk_row(1'b1, 4'd4, 24'd500000, 1'b1, 1'b1, flags_t'(4'b0000)));
    // Shower threshold is strict: the third plate at threshold counts down
    rows.push_back(mk_row(1'b0, 4'd0, 24'd45001, 1'b0, 1'b0, '0));
    rows.push_back(mk_row(1'b0, 4'd1, 24'd45001, 1'b0, 1'b0, '0));
    rows.push_back(mk_row(1'b0, 4'd2, 24'd45000, 1'b1, 1'b0, '0));
    // Plates out of order: no restart, count reaches three past the pi0 limit
    rows.push_back(mk_row(1'b0, 4'd5, EnergyTop, 1'b0, 1'b0, '0));
    rows.push_back(mk_row(1'b0, 4'd3, EnergyTop, 1'b0, 1'b0, '0));
    rows.push_back(mk_row(1'b0, 4'd9, EnergyTop, 1'b1, 1'b0, '0));
    // Last plate at full scale alone
    rows.push_back(mk_row(1'b1, 4'd15, EnergyTop, 1'b1, 1'b1, flags_t'(4'b0000)));
    // Only tower 1 fires early: shower without pi0
    rows.push_back(mk_row(1'b1, 4'd0, EnergyTop, 1'b0, 1'b0, '0));
    rows.push_back(mk_row(1'b1, 4'd1, EnergyTop, 1'b0, 1'b0, '0));
    rows.push_back(mk_row(1'b1, 4'd2, EnergyTop, 1'b0, 1'b0, '0));
    rows.push_back(mk_row(1'b1, 4'd3, 24'd0, 1'b0, 1'b0, '0));
    rows.push_back(mk_row(1'b0, 4'd0, 24'd0, 1'b1, 1'b0, '0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[ph]) begin
      if (ph > 0) begin
        wait_idle();
        apply_config(plan[ph]);
      end else begin
        foreach (rows[i]) send_word(rows[i].s, rows[i].typed, rows[i].want);
      end
      phase_start = sent_words;
      while (sent_words - phase_start < PhaseWords) send_shower_event();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("calorimeter_layer_trigger_core: match");
    end else begin
      $display("calorimeter_layer_trigger_core: mismatch");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #10000000;
    $display("calorimeter_layer_trigger_core: mismatch");
    $finish;
  end

endmodule
